// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers included by the allocator unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, masked while reset is high.
`define FSBA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same check, also evaluated during reset.
`define FSBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/fsba_pkg.sv =====
`default_nettype none

package fsba_pkg;

  // Pool geometry
  localparam int BLOCK_COUNT = 256;
  localparam int BLOCK_BYTES = 64;
  localparam int ADDR_W      = 32;
  localparam int IDX_W       = $clog2(BLOCK_COUNT);
  localparam int COUNT_W     = $clog2(BLOCK_COUNT) + 1;

  // Request codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Response status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic             command;
    logic [IDX_W-1:0] free_index;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [IDX_W-1:0]  block_index;
    logic [ADDR_W-1:0] block_address;
  } rsp_t;

  // Stack memory access for one cycle
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fsba_stack_ram.sv =====
`default_nettype none

// Free-index stack storage: one write and one registered read per cycle.
// An entry that was never written reads as its own address (reset image).
module fsba_stack_ram (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire fsba_pkg::ram_req_t        req,
  output logic [fsba_pkg::IDX_W-1:0]     rdata
);

  logic [fsba_pkg::IDX_W-1:0] mem [fsba_pkg::BLOCK_COUNT];
  logic [fsba_pkg::BLOCK_COUNT-1:0] written;
  logic [fsba_pkg::IDX_W-1:0] data_q;
  logic [fsba_pkg::IDX_W-1:0] raddr_q;
  logic                       written_q;

  // Data array and registered read port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      data_q  <= mem[req.raddr];
      raddr_q <= req.raddr;
    end
  end

  // Per-entry written flags, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      written_q <= 1'b0;
    end else begin
      if (req.we) begin
        written[req.waddr] <= 1'b1;
      end
      if (req.re) begin
        written_q <= written[req.raddr];
      end
    end
  end

  assign rdata = written_q ? data_q : raddr_q;

endmodule

`default_nettype wire

// ===== hw/rtl/free_stack_block_allocator_unit.sv =====
// An accepted request is held as the pending item; its response is registered when
// the response slot frees up. One request per cycle while rsp_ready is high; the
// stack top is read from the RAM at acceptance, and an alloc right after a free
// reads back the entry just written. Reset (rst, synchronous): stack holds
// 0..BLOCK_COUNT-1, count full, pool_base 0; no clearing pass, written flags clear.
`default_nettype none

module free_stack_block_allocator_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         req_valid,
  output logic                              req_ready,
  input  wire fsba_pkg::req_t               req,
  output logic                              rsp_valid,
  input  wire logic                         rsp_ready,
  output fsba_pkg::rsp_t                    rsp,
  input  wire logic                         cfg_we,
  input  wire logic [fsba_pkg::ADDR_W-1:0]  cfg_wdata
);

  `include "assert_macros.svh"

  logic [fsba_pkg::ADDR_W-1:0]  pool_base;
  logic [fsba_pkg::COUNT_W-1:0] count;
  logic [fsba_pkg::COUNT_W-1:0] count_next;
  logic [fsba_pkg::COUNT_W-1:0] count_m1;
  logic                         busy;
  logic                         item_ok;
  logic [1:0]                   item_status;
  logic [1:0]                   status_next;
  logic                         ok_next;
  logic                         accept;
  logic                         complete;
  logic                         is_empty;
  logic                         is_full;
  fsba_pkg::ram_req_t           ram_req;
  logic [fsba_pkg::IDX_W-1:0]   ram_rdata;
  fsba_pkg::rsp_t               rsp_next;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
    end else if (cfg_we) begin
      pool_base <= cfg_wdata;
    end
  end

  // Handshake: the pending item retires when the response slot frees up
  assign complete  = busy && (!rsp_valid || rsp_ready);
  assign req_ready = !busy || complete;
  assign accept    = req_valid && req_ready;

  assign is_empty = (count == '0);
  assign is_full  = (count >= fsba_pkg::COUNT_W'(fsba_pkg::BLOCK_COUNT));
  assign count_m1 = count - fsba_pkg::COUNT_W'(1);

  // Push/pop decision at acceptance
  always_comb begin
    ram_req     = '0;
    count_next  = count;
    status_next = fsba_pkg::ST_OK;
    ok_next     = 1'b0;
    ram_req.waddr = count[fsba_pkg::IDX_W-1:0];
    ram_req.wdata = req.free_index;
    ram_req.raddr = count_m1[fsba_pkg::IDX_W-1:0];
    if (accept) begin
      unique case (req.command)
        fsba_pkg::CMD_ALLOC: begin
          if (is_empty) begin
            status_next = fsba_pkg::ST_EMPTY;
          end else begin
            ok_next    = 1'b1;
            ram_req.re = 1'b1;
            count_next = count_m1;
          end
        end
        fsba_pkg::CMD_FREE: begin
          if (is_full) begin
            status_next = fsba_pkg::ST_FULL;
          end else begin
            ram_req.we = 1'b1;
            count_next = count + fsba_pkg::COUNT_W'(1);
          end
        end
        default: begin
          status_next = fsba_pkg::ST_OK;
        end
      endcase
    end
  end

  fsba_stack_ram u_stack (
    .clk   (clk),
    .rst   (rst),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= fsba_pkg::COUNT_W'(fsba_pkg::BLOCK_COUNT);
      busy  <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        busy <= 1'b1;
      end else if (complete) begin
        busy <= 1'b0;
      end
    end
  end

  // Pending item payload
  always_ff @(posedge clk) begin
    if (accept) begin
      item_ok     <= ok_next;
      item_status <= status_next;
    end
  end

  // Response formation from the popped index
  always_comb begin
    rsp_next.status        = item_status;
    rsp_next.block_index   = item_ok ? ram_rdata : '0;
    rsp_next.block_address = item_ok
      ? pool_base + fsba_pkg::ADDR_W'(ram_rdata) * fsba_pkg::ADDR_W'(fsba_pkg::BLOCK_BYTES)
      : '0;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (complete) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (complete) begin
      rsp <= rsp_next;
    end
  end

  // Checks
  `FSBA_ASSERT(a_count_range, clk, rst,
    count <= fsba_pkg::COUNT_W'(fsba_pkg::BLOCK_COUNT), "free count above pool size")
  `FSBA_ASSERT(a_accept_busy, clk, rst, accept |=> busy, "accepted request not pending")
  `FSBA_ASSERT(a_fail_zero, clk, rst,
    (rsp_valid && rsp.status != fsba_pkg::ST_OK)
      |-> (rsp.block_index == '0 && rsp.block_address == '0),
    "failed response carries nonzero index or address")
  `FSBA_ASSERT(a_pop_count, clk, rst,
    (accept && req.command == fsba_pkg::CMD_ALLOC && !is_empty) |=> (count == $past(count_m1)),
    "pop did not decrement count")

endmodule

`default_nettype wire

// ===== tb/sv/free_stack_block_allocator_unit_tb.sv =====
`default_nettype none

module free_stack_block_allocator_unit_tb;
  import fsba_pkg::*;

  localparam int QUIET_LIMIT = 2000;  // cycles with no transaction before giving up
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int PHASE_ITEMS = 265;
  localparam int NUM_PHASES  = 6;
  localparam int DIR_ROWS    = 21;
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    req_t item;
    logic typed;   // response typed in below instead of taken from the pool model
    rsp_t want;
  } dir_row_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;
  logic cfg_we;
  logic [ADDR_W-1:0] cfg_wdata;

  // Side info that travels with each request
  logic req_typed;
  rsp_t req_fixed;

  // Pool model state
  logic [IDX_W-1:0]  pool_stack [BLOCK_COUNT];
  int                pool_free;
  logic [ADDR_W-1:0] pool_base;
  rsp_t              pending_grants [$];

  int   err_count;
  int   quiet_cycles;
  int   burst_left;
  bit   gaps_on;
  bit   hold_req;
  dir_row_t script [DIR_ROWS];

  free_stack_block_allocator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Pop or push the free stack for one request and return its response
  function automatic rsp_t pool_service(input req_t r);
    rsp_t g;
    g = '0;
    if (r.command == CMD_ALLOC) begin
      if (pool_free == 0) begin
        g.status = ST_EMPTY;
      end else begin
        pool_free--;
        g.status        = ST_OK;
        g.block_index   = pool_stack[pool_free];
        g.block_address = pool_base + ADDR_W'(g.block_index) * ADDR_W'(BLOCK_BYTES);
      end
    end else begin
      if (pool_free >= BLOCK_COUNT) begin
        g.status = ST_FULL;
      end else begin
        pool_stack[pool_free] = r.free_index;
        pool_free++;
      end
    end
    return g;
  endfunction

  task automatic report_field(input string name, input logic [ADDR_W-1:0] want,
                              input logic [ADDR_W-1:0] got);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
  endtask

  // Monitor: check responses first, then log the request, then config writes
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < BLOCK_COUNT; i++) pool_stack[i] = IDX_W'(i);
      pool_free = BLOCK_COUNT;
      pool_base = '0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (pending_grants.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: unexpected response, expected none, actual %p", $time, rsp);
        end else begin
          want = pending_grants.pop_front();
          if (rsp.status !== want.status)
            report_field("status", ADDR_W'(want.status), ADDR_W'(rsp.status));
          if (rsp.block_index !== want.block_index)
            report_field("block_index", ADDR_W'(want.block_index), ADDR_W'(rsp.block_index));
          if (rsp.block_address !== want.block_address)
            report_field("block_address", want.block_address, rsp.block_address);
        end
      end
      if (req_valid && req_ready) begin
        want = pool_service(req);
        pending_grants.push_back(req_typed ? req_fixed : want);
      end
      if (cfg_we) pool_base = cfg_wdata;
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: changes its stall pattern now and then, long hold-off on request
  initial begin
    int mode;
    int mode_left;
    int phase;
    rsp_ready = 1'b0;
    mode = 0;
    mode_left = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        phase++;
        case (mode)
          0: begin
            rsp_ready <= 1'b1;
          end
          1: begin
            rsp_ready <= 1'($urandom_range(0, 1));
          end
          2: begin
            rsp_ready <= (phase % 4) != 3;
          end
          default: begin
            rsp_ready <= ($urandom_range(0, 7) == 0);
          end
        endcase
      end
    end
  end

  // Offer one request and hold it until accepted; the sender idles between bursts when gaps_on is set
  task automatic offer(input req_t r, input logic typed, input rsp_t fixed);
    req_valid <= 1'b1;
    req       <= r;
    req_typed <= typed;
    req_fixed <= fixed;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        req_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Write pool_base once the block has gone idle
  task automatic write_base(input logic [ADDR_W-1:0] value);
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic req_t random_item(input int alloc_pct);
    req_t r;
    int pick;
    r.command = ($urandom_range(0, 99) < alloc_pct) ? CMD_ALLOC : CMD_FREE;
    pick = $urandom_range(0, 7);
    if (pick == 0) r.free_index = '0;
    else if (pick == 1) r.free_index = '1;
    else r.free_index = IDX_W'($urandom_range(0, BLOCK_COUNT - 1));
    return r;
  endfunction

  initial begin
    logic [ADDR_W-1:0] bases [NUM_PHASES];
    int alloc_pct [NUM_PHASES];
    rst        = 1'b1;
    req_valid  = 1'b0;
    req        = '0;
    req_typed  = 1'b0;
    req_fixed  = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    err_count  = 0;
    burst_left = 0;
    gaps_on    = 1'b1;
    hold_req   = 1'b0;

    // Directed rows, pool_base still 0 from reset
    script = '{
      '{'{CMD_FREE,  8'h00}, 1'b1, '{ST_FULL,  8'h00, 32'h0000_0000}},  // free on full stack
      '{'{CMD_FREE,  8'hFF}, 1'b1, '{ST_FULL,  8'h00, 32'h0000_0000}},
      '{'{CMD_ALLOC, 8'h00}, 1'b1, '{ST_OK,    8'hFF, 32'h0000_3FC0}},  // top is highest index
      '{'{CMD_ALLOC, 8'hFF}, 1'b1, '{ST_OK,    8'hFE, 32'h0000_3F80}},
      '{'{CMD_FREE,  8'h00}, 1'b1, '{ST_OK,    8'h00, 32'h0000_0000}},
      '{'{CMD_FREE,  8'hFF}, 1'b1, '{ST_OK,    8'h00, 32'h0000_0000}},
      '{'{CMD_FREE,  8'hAA}, 1'b1, '{ST_FULL,  8'h00, 32'h0000_0000}},  // index dropped
      '{'{CMD_ALLOC, 8'h00}, 1'b1, '{ST_OK,    8'hFF, 32'h0000_3FC0}},
      '{'{CMD_ALLOC, 8'h00}, 1'b1, '{ST_OK,    8'h00, 32'h0000_0000}},
      '{'{CMD_FREE,  8'h55}, 1'b0, '0},
      '{'{CMD_FREE,  8'hAA}, 1'b0, '0},
      '{'{CMD_ALLOC, 8'h00}, 1'b0, '0},
      '{'{CMD_ALLOC, 8'hFF}, 1'b0, '0},
      '{'{CMD_FREE,  8'h00}, 1'b0, '0},
      '{'{CMD_FREE,  8'hFF}, 1'b0, '0},
      '{'{CMD_ALLOC, 8'h00}, 1'b0, '0},
      '{'{CMD_ALLOC, 8'h00}, 1'b0, '0},
      '{'{CMD_FREE,  8'h3C}, 1'b0, '0},                                 // double free
      '{'{CMD_FREE,  8'h3C}, 1'b0, '0},
      '{'{CMD_ALLOC, 8'h00}, 1'b0, '0},
      '{'{CMD_ALLOC, 8'h00}, 1'b0, '0}
    };

    // Phase plan: drain to empty, refill to full, mixed; base extremes and wrap
    bases     = '{32'hFFFF_FFFF, 32'hFFFF_C000, $urandom, 32'h8000_0000, 32'h0000_0000, $urandom};
    alloc_pct = '{96, 4, 50, 96, 4, 50};

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      offer(script[i].item, script[i].typed, script[i].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_base(bases[p]);
      gaps_on = (p % 3) != 2;
      if (p == 2) hold_req = 1'b1;   // receiver stalls while items keep coming
      for (int n = 0; n < PHASE_ITEMS; n++)
        offer(random_item(alloc_pct[p]), 1'b0, '0);
    end

    // Drain
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
